@@ hw/rtl/prf_pkg.sv @@
// ----------------------------------------------------------------------------
// prf_pkg - shared types and constants
// Command codes, back-end states, policy codes and register map of the
// page frame replacement unit.
// ----------------------------------------------------------------------------
package prf_pkg;

    // Register map: one bit of paddr picks the register
    localparam int CFG_ADDR_W = 3;
    localparam logic REG_POLICY = 1'b0;
    localparam logic REG_FRAMES = 1'b1;

    // Register widths and reset values
    localparam int POLICY_W = 2;
    localparam int FIU_W    = 4;
    localparam logic [POLICY_W-1:0] POLICY_RESET = 2'd0;
    localparam logic [FIU_W-1:0]    FRAMES_RESET = 4'd8;

    // Replacement policy codes; the unused code falls back to FIFO
    localparam logic [POLICY_W-1:0] POL_FIFO  = 2'd0;
    localparam logic [POLICY_W-1:0] POL_LRU   = 2'd1;
    localparam logic [POLICY_W-1:0] POL_CLOCK = 2'd2;

    // Ages and fault counter saturate at all ones
    localparam int AGE_W   = 16;
    localparam int COUNT_W = 16;
    localparam logic [AGE_W-1:0]   AGE_MAX   = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Classified reference, as passed from front to back
    typedef enum logic [1:0] {
        CMD_HIT,
        CMD_FILL,
        CMD_EVICT
    } cmd_kind_t;

    localparam int KIND_W = $bits(cmd_kind_t);

    // Back-end sequencer
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_LRU,
        BK_CLOCK,
        BK_COMMIT
    } bk_state_t;

endpackage

@@ hw/rtl/prf_front.sv @@
// ----------------------------------------------------------------------------
// prf_front - reference intake and classification
// Takes one page reference, matches it against the resident frames and
// issues a hit, fill or evict command to the back end.
// ----------------------------------------------------------------------------
module prf_front
    import prf_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_WIDTH = 16,
    parameter int SLOT_W     = 3,
    parameter int CNT_W      = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [PAGE_WIDTH-1:0] page_number,
    input  logic [CNT_W-1:0]      active_n,
    input  logic [PAGE_WIDTH-1:0] frame_pages [FRAMES],
    input  logic                  frame_valid [FRAMES],
    output logic                  front_busy,
    output logic                  cmd_push,
    output cmd_kind_t             cmd_kind,
    output logic [SLOT_W-1:0]     cmd_slot,
    output logic [PAGE_WIDTH-1:0] cmd_page
);

    logic                  pend_reg;
    logic                  pend_next;
    logic [PAGE_WIDTH-1:0] page_reg;
    logic [PAGE_WIDTH-1:0] page_next;

    logic                  hit_found;
    logic [SLOT_W-1:0]     hit_slot;
    logic                  empty_found;
    logic [SLOT_W-1:0]     empty_slot;

    // Capture the word on acceptance and register it for classification
    always_comb
    begin
        pend_next = start && !busy;
        page_next = (start && !busy) ? page_number : page_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        page_reg <= page_next;
    end

    // Find the lowest matching frame and the lowest empty frame
    always_comb
    begin
        hit_found   = 1'b0;
        hit_slot    = '0;
        empty_found = 1'b0;
        empty_slot  = '0;
        for (int j = FRAMES - 1; j >= 0; j--)
        begin
            if (CNT_W'(j) < active_n)
            begin
                if (frame_valid[j] && (frame_pages[j] == page_reg))
                begin
                    hit_found = 1'b1;
                    hit_slot  = SLOT_W'(j);
                end
                if (!frame_valid[j])
                begin
                    empty_found = 1'b1;
                    empty_slot  = SLOT_W'(j);
                end
            end
        end
    end

    // Issue the command
    always_comb
    begin
        cmd_push = pend_reg;
        cmd_page = page_reg;
        if (hit_found)
        begin
            cmd_kind = CMD_HIT;
            cmd_slot = hit_slot;
        end
        else if (empty_found)
        begin
            cmd_kind = CMD_FILL;
            cmd_slot = empty_slot;
        end
        else
        begin
            cmd_kind = CMD_EVICT;
            cmd_slot = '0;
        end
    end

    assign front_busy = pend_reg;

endmodule

@@ hw/rtl/prf_queue.sv @@
// ----------------------------------------------------------------------------
// prf_queue - command queue
// Small first-in first-out buffer between the front and back ends.
// ----------------------------------------------------------------------------
module prf_queue
    import prf_pkg::*;
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         not_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  entries_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    // Drop a push when full, ignore a pop when empty
    always_comb
    begin
        do_push     = push && (count_reg != CW'(DEPTH));
        do_pop      = pop && (count_reg != '0);
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the word at the write pointer
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= din;
        end
    end

    assign dout      = entries_reg[rd_ptr_reg];
    assign not_empty = (count_reg != '0);

endmodule

@@ hw/rtl/prf_back.sv @@
// ----------------------------------------------------------------------------
// prf_back - frame table and replacement sequencer
// Holds the frame table, picks a victim by FIFO pointer, LRU age scan or
// clock sweep, commits the update, ages the frames and returns the result.
// ----------------------------------------------------------------------------
module prf_back
    import prf_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_WIDTH = 16,
    parameter int SLOT_W     = 3,
    parameter int CNT_W      = 4
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [CNT_W-1:0]      active_n,
    input  logic [POLICY_W-1:0]   policy,
    input  logic                  cmd_valid,
    input  cmd_kind_t             cmd_kind,
    input  logic [SLOT_W-1:0]     cmd_slot,
    input  logic [PAGE_WIDTH-1:0] cmd_page,
    output logic                  cmd_pop,
    output logic                  back_busy,
    output logic [PAGE_WIDTH-1:0] frame_pages [FRAMES],
    output logic                  frame_valid [FRAMES],
    output logic                  done,
    output logic                  fault,
    output logic [SLOT_W-1:0]     slot,
    output logic                  evicted_valid,
    output logic [PAGE_WIDTH-1:0] evicted_page,
    output logic [COUNT_W-1:0]    fault_count
);

    bk_state_t             state_reg;
    bk_state_t             state_next;
    cmd_kind_t             kind_reg;
    cmd_kind_t             kind_next;
    logic [SLOT_W-1:0]     slot_reg;
    logic [SLOT_W-1:0]     slot_next;
    logic [PAGE_WIDTH-1:0] page_reg;
    logic [PAGE_WIDTH-1:0] page_next;
    logic [CNT_W-1:0]      scan_reg;
    logic [CNT_W-1:0]      scan_next;
    logic [SLOT_W-1:0]     best_reg;
    logic [SLOT_W-1:0]     best_next;
    logic [AGE_W-1:0]      best_age_reg;
    logic [AGE_W-1:0]      best_age_next;
    logic [SLOT_W-1:0]     ptr_reg;
    logic [SLOT_W-1:0]     ptr_next;
    logic [SLOT_W-1:0]     vptr_reg;
    logic [SLOT_W-1:0]     vptr_next;

    logic [PAGE_WIDTH-1:0] pages_reg [FRAMES];
    logic [PAGE_WIDTH-1:0] pages_next [FRAMES];
    logic                  valid_reg [FRAMES];
    logic                  valid_next [FRAMES];
    logic [AGE_W-1:0]      ages_reg [FRAMES];
    logic [AGE_W-1:0]      ages_next [FRAMES];
    logic                  ref_reg [FRAMES];
    logic                  ref_next [FRAMES];
    logic [COUNT_W-1:0]    faults_reg;
    logic [COUNT_W-1:0]    faults_next;

    logic                  done_reg;
    logic                  done_next;
    logic                  fault_o_reg;
    logic                  fault_o_next;
    logic [SLOT_W-1:0]     slot_o_reg;
    logic [SLOT_W-1:0]     slot_o_next;
    logic                  evv_reg;
    logic                  evv_next;
    logic [PAGE_WIDTH-1:0] evp_reg;
    logic [PAGE_WIDTH-1:0] evp_next;

    logic [SLOT_W-1:0]     start_ptr;
    logic [SLOT_W-1:0]     scan_idx;

    // Pointer beyond the active frames restarts at zero
    function automatic logic [SLOT_W-1:0] restart_ptr(
        input logic [SLOT_W-1:0] p,
        input logic [CNT_W-1:0]  n
    );
        logic [SLOT_W-1:0] r;
        r = (CNT_W'(p) >= n) ? '0 : p;
        return r;
    endfunction

    // Step the pointer modulo the active frame count
    function automatic logic [SLOT_W-1:0] step_ptr(
        input logic [SLOT_W-1:0] p,
        input logic [CNT_W-1:0]  n
    );
        logic [CNT_W-1:0] s;
        s = CNT_W'(p) + CNT_W'(1);
        return (s >= n) ? '0 : SLOT_W'(s);
    endfunction

    assign start_ptr = restart_ptr(vptr_reg, active_n);
    assign scan_idx  = SLOT_W'(scan_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (cmd_kind == CMD_EVICT)
                    begin
                        case (policy)
                            POL_LRU:   state_next = BK_LRU;
                            POL_CLOCK: state_next = BK_CLOCK;
                            default:   state_next = BK_COMMIT;
                        endcase
                    end
                    else
                    begin
                        state_next = BK_COMMIT;
                    end
                end
            end
            BK_LRU:
            begin
                if (scan_reg >= active_n)
                begin
                    state_next = BK_COMMIT;
                end
            end
            BK_CLOCK:
            begin
                if (!ref_reg[ptr_reg])
                begin
                    state_next = BK_COMMIT;
                end
            end
            BK_COMMIT:
            begin
                state_next = BK_IDLE;
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    // Datapath and result
    always_comb
    begin
        kind_next     = kind_reg;
        slot_next     = slot_reg;
        page_next     = page_reg;
        scan_next     = scan_reg;
        best_next     = best_reg;
        best_age_next = best_age_reg;
        ptr_next      = ptr_reg;
        vptr_next     = vptr_reg;
        pages_next    = pages_reg;
        valid_next    = valid_reg;
        ages_next     = ages_reg;
        ref_next      = ref_reg;
        faults_next   = faults_reg;
        done_next     = 1'b0;
        fault_o_next  = fault_o_reg;
        slot_o_next   = slot_o_reg;
        evv_next      = evv_reg;
        evp_next      = evp_reg;
        cmd_pop       = 1'b0;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop       = 1'b1;
                    kind_next     = cmd_kind;
                    slot_next     = cmd_slot;
                    page_next     = cmd_page;
                    scan_next     = CNT_W'(1);
                    best_next     = '0;
                    best_age_next = ages_reg[0];
                    ptr_next      = start_ptr;
                    // FIFO takes the pointer at once
                    if ((cmd_kind == CMD_EVICT) && (policy != POL_LRU)
                        && (policy != POL_CLOCK))
                    begin
                        slot_next = start_ptr;
                        vptr_next = step_ptr(start_ptr, active_n);
                    end
                end
            end
            BK_LRU:
            begin
                // Scan one frame a cycle, keep the first oldest
                if (scan_reg < active_n)
                begin
                    if (ages_reg[scan_idx] > best_age_reg)
                    begin
                        best_next     = scan_idx;
                        best_age_next = ages_reg[scan_idx];
                    end
                    scan_next = scan_reg + CNT_W'(1);
                end
                else
                begin
                    slot_next = best_reg;
                end
            end
            BK_CLOCK:
            begin
                // Clear a set reference bit and advance, else take the frame
                if (ref_reg[ptr_reg])
                begin
                    ref_next[ptr_reg] = 1'b0;
                    ptr_next          = step_ptr(ptr_reg, active_n);
                end
                else
                begin
                    slot_next = ptr_reg;
                    vptr_next = step_ptr(ptr_reg, active_n);
                end
            end
            BK_COMMIT:
            begin
                done_next    = 1'b1;
                fault_o_next = (kind_reg != CMD_HIT);
                slot_o_next  = slot_reg;
                evv_next     = (kind_reg == CMD_EVICT);
                evp_next     = (kind_reg == CMD_EVICT) ? pages_reg[slot_reg] : '0;
                if ((kind_reg != CMD_HIT) && (faults_reg != COUNT_MAX))
                begin
                    faults_next = faults_reg + COUNT_W'(1);
                end
                // Install the page and age every occupied active frame
                for (int j = 0; j < FRAMES; j++)
                begin
                    if (SLOT_W'(j) == slot_reg)
                    begin
                        pages_next[j] = page_reg;
                        valid_next[j] = 1'b1;
                        ages_next[j]  = AGE_W'(1);
                        ref_next[j]   = (kind_reg == CMD_HIT);
                    end
                    else if (valid_reg[j] && (CNT_W'(j) < active_n)
                             && (ages_reg[j] != AGE_MAX))
                    begin
                        ages_next[j] = ages_reg[j] + AGE_W'(1);
                    end
                end
            end
            default:
            begin
                cmd_pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_IDLE;
            vptr_reg   <= '0;
            faults_reg <= '0;
            done_reg   <= 1'b0;
            for (int j = 0; j < FRAMES; j++)
            begin
                valid_reg[j] <= 1'b0;
                ages_reg[j]  <= '0;
                ref_reg[j]   <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            vptr_reg   <= vptr_next;
            faults_reg <= faults_next;
            done_reg   <= done_next;
            valid_reg  <= valid_next;
            ages_reg   <= ages_next;
            ref_reg    <= ref_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        slot_reg     <= slot_next;
        page_reg     <= page_next;
        scan_reg     <= scan_next;
        best_reg     <= best_next;
        best_age_reg <= best_age_next;
        ptr_reg      <= ptr_next;
        pages_reg    <= pages_next;
        fault_o_reg  <= fault_o_next;
        slot_o_reg   <= slot_o_next;
        evv_reg      <= evv_next;
        evp_reg      <= evp_next;
    end

    assign back_busy     = (state_reg != BK_IDLE);
    assign frame_pages   = pages_reg;
    assign frame_valid   = valid_reg;
    assign done          = done_reg;
    assign fault         = fault_o_reg;
    assign slot          = slot_o_reg;
    assign evicted_valid = evv_reg;
    assign evicted_page  = evp_reg;
    assign fault_count   = faults_reg;

endmodule

@@ hw/rtl/page_frame_replacement_unit.sv @@
// ----------------------------------------------------------------------------
// page_frame_replacement_unit - page frame replacement unit
// Tracks the pages resident in a set of frames and replaces them by FIFO,
// LRU or second-chance clock policy, one page reference at a time.
// ----------------------------------------------------------------------------
//
//  Channel    Handshake                       Payload
//  ---------  ------------------------------  ---------------------------------
//  reference  start & !busy                   page_number
//  result     done (one cycle, no stall)      fault, slot, evicted_valid,
//                                             evicted_page, fault_count
//  config     psel & penable & pwrite         paddr, pwdata / prdata
//
//  A reference goes from the front-end classify register through the
//  command queue to the back-end sequencer, which commits it; an eviction
//  under LRU or clock first runs the age scan or the sweep. The back-end
//  sequencer handles one reference at a time; busy is low again in the
//  cycle done is high, so the next reference may be accepted alongside
//  the result. Reset empties all frames and clears ages, reference bits,
//  the victim pointer and the fault count. Results cannot be held off by
//  the receiver.
module page_frame_replacement_unit
    import prf_pkg::*;
#(
    parameter int FRAMES     = 8,
    parameter int PAGE_WIDTH = 16,
    localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PAGE_WIDTH-1:0] page_number,
    output logic                  done,
    output logic                  fault,
    output logic [SLOT_W-1:0]     slot,
    output logic                  evicted_valid,
    output logic [PAGE_WIDTH-1:0] evicted_page,
    output logic [COUNT_W-1:0]    fault_count,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int CNT_W = $clog2(FRAMES + 1);
    localparam int QW    = KIND_W + SLOT_W + PAGE_WIDTH;

    logic [POLICY_W-1:0]   policy_reg;
    logic [FIU_W-1:0]      frames_reg;
    logic [CNT_W-1:0]      active_n;
    logic                  cfg_write;

    logic                  front_busy;
    logic                  back_busy;
    logic                  cmd_push;
    cmd_kind_t             push_kind;
    logic [SLOT_W-1:0]     push_slot;
    logic [PAGE_WIDTH-1:0] push_page;
    logic [QW-1:0]         q_din;
    logic [QW-1:0]         q_dout;
    logic                  q_not_empty;
    logic                  cmd_pop;
    cmd_kind_t             pop_kind;
    logic [SLOT_W-1:0]     pop_slot;
    logic [PAGE_WIDTH-1:0] pop_page;

    logic [PAGE_WIDTH-1:0] frame_pages [FRAMES];
    logic                  frame_valid [FRAMES];

    // Configuration writes
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg <= POLICY_RESET;
            frames_reg <= FRAMES_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_POLICY: policy_reg <= pwdata[POLICY_W-1:0];
                REG_FRAMES: frames_reg <= pwdata[FIU_W-1:0];
                default:    policy_reg <= policy_reg;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (paddr[2])
            REG_POLICY: prdata = 32'(policy_reg);
            REG_FRAMES: prdata = 32'(frames_reg);
            default:    prdata = '0;
        endcase
    end

    // Clamp the frame count to 1..FRAMES
    always_comb
    begin
        if (frames_reg == '0)
        begin
            active_n = CNT_W'(1);
        end
        else if (32'(frames_reg) > FRAMES)
        begin
            active_n = CNT_W'(FRAMES);
        end
        else
        begin
            active_n = CNT_W'(frames_reg);
        end
    end

    // Busy while a word is anywhere between intake and commit
    assign busy = front_busy || q_not_empty || back_busy;

    prf_front #(
        .FRAMES     (FRAMES),
        .PAGE_WIDTH (PAGE_WIDTH),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .page_number (page_number),
        .active_n    (active_n),
        .frame_pages (frame_pages),
        .frame_valid (frame_valid),
        .front_busy  (front_busy),
        .cmd_push    (cmd_push),
        .cmd_kind    (push_kind),
        .cmd_slot    (push_slot),
        .cmd_page    (push_page)
    );

    assign q_din = {push_kind, push_slot, push_page};

    prf_queue #(
        .W     (QW),
        .DEPTH (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (cmd_push),
        .din       (q_din),
        .pop       (cmd_pop),
        .dout      (q_dout),
        .not_empty (q_not_empty)
    );

    assign pop_kind = cmd_kind_t'(q_dout[QW-1 -: KIND_W]);
    assign pop_slot = q_dout[PAGE_WIDTH +: SLOT_W];
    assign pop_page = q_dout[PAGE_WIDTH-1:0];

    prf_back #(
        .FRAMES     (FRAMES),
        .PAGE_WIDTH (PAGE_WIDTH),
        .SLOT_W     (SLOT_W),
        .CNT_W      (CNT_W)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .active_n      (active_n),
        .policy        (policy_reg),
        .cmd_valid     (q_not_empty),
        .cmd_kind      (pop_kind),
        .cmd_slot      (pop_slot),
        .cmd_page      (pop_page),
        .cmd_pop       (cmd_pop),
        .back_busy     (back_busy),
        .frame_pages   (frame_pages),
        .frame_valid   (frame_valid),
        .done          (done),
        .fault         (fault),
        .slot          (slot),
        .evicted_valid (evicted_valid),
        .evicted_page  (evicted_page),
        .fault_count   (fault_count)
    );

endmodule

@@ hw/rtl/prf_checker.sv @@
// ----------------------------------------------------------------------------
// prf_checker - port-level checks
// Watches the top-level ports for result sequencing and payload consistency.
// ----------------------------------------------------------------------------
module prf_checker
    import prf_pkg::*;
#(
    parameter int PAGE_WIDTH = 16
)
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic                  fault,
    input logic                  evicted_valid,
    input logic [PAGE_WIDTH-1:0] evicted_page
);

    // An accepted word keeps the unit busy in the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // A result is shown only once the unit has drained
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    // One word gives one result strobe
    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe held for two cycles");

    // A hit never evicts
    a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !fault) |-> (!evicted_valid && (evicted_page == '0)))
        else $error("hit reported an eviction");

    // An eviction is always a fault
    a_evict_fault: assert property (@(posedge clk) disable iff (!rst_n)
        (done && evicted_valid) |-> fault)
        else $error("eviction without fault");

endmodule

bind page_frame_replacement_unit prf_checker #(
    .PAGE_WIDTH (PAGE_WIDTH)
) u_prf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .done          (done),
    .fault         (fault),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page)
);
